// ----- hw/rtl/assert_macros.svh -----
// assert_macros.svh: concurrent assertion wrappers for the stop and clearance timing block.
// Expects i_clk and i_rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising edge outside reset
`define VSCT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// check that post holds in the cycle after pre
`define VSCT_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- hw/rtl/vsct_pkg.sv -----
// vsct_pkg: types, constants and step functions of the stop and clearance timing block.
// No dependencies; used by vsct_div3, vsct_sqrt2 and the top level.
`default_nettype none

package vsct_pkg;

    localparam int DIV_STAGES = 64;
    localparam int SQ_STAGES  = 32;
    localparam int LANES_DIV  = 3;
    localparam int LANES_SQ   = 2;

    localparam logic [1:0] CLS_ENTER  = 2'd0;
    localparam logic [1:0] CLS_READY  = 2'd1;
    localparam logic [1:0] CLS_DEPART = 2'd2;
    localparam logic [1:0] CLS_LEFT   = 2'd3;

    localparam logic signed [31:0] DMIN      = 32'sd655;
    localparam logic signed [63:0] TMIN      = 64'sd655;
    localparam logic [56:0]        TERM_CAP  = {1'b1, 56'b0};
    localparam logic [47:0]        STOP_MAX  = 48'hFFFF_FFFF_FFFF;
    localparam logic [15:0]        CLEAR_MAX = 16'hFFFF;

    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] lo;
        logic [63:0] den;
    } t_div_st;

    typedef struct packed {
        logic [63:0] x;
        logic [33:0] rem;
        logic [31:0] root;
    } t_sq_st;

    typedef struct packed {
        logic [1:0]         cls;
        logic [47:0]        now;
        logic [30:0]        v;
        logic [30:0]        a;
        logic [31:0]        bmag;
        logic [30:0]        lim;
        logic [30:0]        klim;
        logic [30:0]        len;
        logic signed [31:0] d;
        logic [31:0]        dx1;
        logic [61:0]        v2;
        logic [61:0]        l2;
        logic [61:0]        k2;
        logic [62:0]        two_al;
        logic [63:0]        dx1b2;
        logic [63:0]        mag;
        logic [62:0]        two_ak;
        logic [61:0]        kv2;
        logic [63:0]        two_dxa;
        logic [63:0]        inner;
        logic               emerg;
        logic               l_ge_v;
        logic               clr_sqrt;
        logic [63:0]        clr_sq_in;
        logic [15:0]        clr_div;
        logic signed [63:0] dx3;
        logic               case_a;
        logic               msat;
        logic [56:0]        tcr;
        logic [32:0]        clr_root;
        logic               neg;
    } t_ctx;

    function automatic t_div_st div_step(input t_div_st s);
        t_div_st    r;
        logic [64:0] t;
        t     = {s.rem, s.lo[63]};
        r.den = s.den;
        r.lo  = {s.lo[62:0], 1'b0};
        if (t >= {1'b0, s.den}) begin
            r.rem   = 64'(t - {1'b0, s.den});
            r.lo[0] = 1'b1;
        end else begin
            r.rem = t[63:0];
        end
        return r;
    endfunction

    function automatic t_sq_st sq_step(input t_sq_st s);
        t_sq_st      r;
        logic [35:0] t;
        logic [35:0] trial;
        t     = {s.rem, s.x[63:62]};
        trial = {2'b00, s.root, 2'b01};
        r.x   = {s.x[61:0], 2'b00};
        if (t >= trial) begin
            r.rem  = 34'(t - trial);
            r.root = {s.root[30:0], 1'b1};
        end else begin
            r.rem  = t[33:0];
            r.root = {s.root[30:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic [15:0] sat16(input logic [64:0] x);
        return (x > 65'(CLEAR_MAX)) ? CLEAR_MAX : x[15:0];
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/vsct_div3.sv -----
// vsct_div3: three-lane restoring divider, one quotient bit per register stage.
// Depends on vsct_pkg; carries the item context alongside the lanes.
`default_nettype none

module vsct_div3 (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire vsct_pkg::t_ctx    i_ctx,
    input  wire vsct_pkg::t_div_st i_lane [vsct_pkg::LANES_DIV],
    output logic                   o_valid,
    output vsct_pkg::t_ctx         o_ctx,
    output vsct_pkg::t_div_st      o_lane [vsct_pkg::LANES_DIV]
);

    logic [vsct_pkg::DIV_STAGES-1:0] r_vld;
    vsct_pkg::t_ctx                  r_ctx [vsct_pkg::DIV_STAGES];
    vsct_pkg::t_div_st               r_st  [vsct_pkg::DIV_STAGES][vsct_pkg::LANES_DIV];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[vsct_pkg::DIV_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctx[0] <= i_ctx;
            for (int l = 0; l < vsct_pkg::LANES_DIV; l++) begin
                r_st[0][l] <= vsct_pkg::div_step(i_lane[l]);
            end
            for (int k = 1; k < vsct_pkg::DIV_STAGES; k++) begin
                r_ctx[k] <= r_ctx[k-1];
                for (int l = 0; l < vsct_pkg::LANES_DIV; l++) begin
                    r_st[k][l] <= vsct_pkg::div_step(r_st[k-1][l]);
                end
            end
        end
    end

    assign o_valid = r_vld[vsct_pkg::DIV_STAGES-1];
    assign o_ctx   = r_ctx[vsct_pkg::DIV_STAGES-1];

    always_comb begin
        for (int l = 0; l < vsct_pkg::LANES_DIV; l++) begin
            o_lane[l] = r_st[vsct_pkg::DIV_STAGES-1][l];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/vsct_sqrt2.sv -----
// vsct_sqrt2: two-lane integer square root, one root bit per register stage.
// Depends on vsct_pkg; carries the item context alongside the lanes.
`default_nettype none

module vsct_sqrt2 (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire vsct_pkg::t_ctx    i_ctx,
    input  wire vsct_pkg::t_sq_st  i_lane [vsct_pkg::LANES_SQ],
    output logic                   o_valid,
    output vsct_pkg::t_ctx         o_ctx,
    output vsct_pkg::t_sq_st       o_lane [vsct_pkg::LANES_SQ]
);

    logic [vsct_pkg::SQ_STAGES-1:0] r_vld;
    vsct_pkg::t_ctx                 r_ctx [vsct_pkg::SQ_STAGES];
    vsct_pkg::t_sq_st               r_st  [vsct_pkg::SQ_STAGES][vsct_pkg::LANES_SQ];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[vsct_pkg::SQ_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctx[0] <= i_ctx;
            for (int l = 0; l < vsct_pkg::LANES_SQ; l++) begin
                r_st[0][l] <= vsct_pkg::sq_step(i_lane[l]);
            end
            for (int k = 1; k < vsct_pkg::SQ_STAGES; k++) begin
                r_ctx[k] <= r_ctx[k-1];
                for (int l = 0; l < vsct_pkg::LANES_SQ; l++) begin
                    r_st[k][l] <= vsct_pkg::sq_step(r_st[k-1][l]);
                end
            end
        end
    end

    assign o_valid = r_vld[vsct_pkg::SQ_STAGES-1];
    assign o_ctx   = r_ctx[vsct_pkg::SQ_STAGES-1];

    always_comb begin
        for (int l = 0; l < vsct_pkg::LANES_SQ; l++) begin
            o_lane[l] = r_st[vsct_pkg::SQ_STAGES-1][l];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/vehicle_stop_clearance_timing_top.sv -----
// vehicle_stop_clearance_timing_top: earliest stop time and link clearance time per vehicle.
// Depends on vsct_pkg, vsct_div3, vsct_sqrt2 and assert_macros.svh.
//
// One input beat carries one vehicle; each accepted beat yields exactly one output beat,
// in order. Input beat: i_in_valid / o_in_ready. Output beat: o_out_valid / i_out_ready.
// Throughput: one beat per cycle unless the output stalls. The chain is three input stages,
// a 64-stage divider, two stages, a 64-stage divider, one stage, a 32-stage square root,
// one stage, a 64-stage divider and two output stages; the dividers set the depth.
// Stall: while the output register holds an untaken beat, the whole pipeline freezes
// and o_in_ready is low; no beat is lost or repeated. Bubbles travel as invalid stages.
// Reset (synchronous, active low) clears every stage valid bit and the output valid.
// stop_time is zero and stop_time_valid low for classes other than entering;
// clear_seconds is zero and clear_valid low for a vehicle that has left.
`default_nettype none
`include "assert_macros.svh"

module vehicle_stop_clearance_timing_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [1:0]         i_vehicle_class,
    input  wire logic [47:0]        i_now_time,
    input  wire logic [30:0]        i_cur_speed,
    input  wire logic signed [31:0] i_stop_distance,
    input  wire logic [30:0]        i_accel_limit,
    input  wire logic signed [31:0] i_decel_limit,
    input  wire logic [30:0]        i_lane_limit,
    input  wire logic [30:0]        i_link_limit,
    input  wire logic [30:0]        i_link_len,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [47:0]             o_stop_time,
    output logic                    o_stop_time_valid,
    output logic [15:0]             o_clear_seconds,
    output logic                    o_clear_valid
);

    logic w_en;

    logic r_v0, r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7;
    logic r_out_valid;

    vsct_pkg::t_ctx n_c0, r_c0, n_c1, r_c1, n_c2, r_c2, n_c3, r_c3, n_c4, r_c4;
    vsct_pkg::t_ctx n_c5, r_c5, n_c6, r_c6, r_c7;

    vsct_pkg::t_div_st n_l2 [vsct_pkg::LANES_DIV];
    vsct_pkg::t_div_st r_l2 [vsct_pkg::LANES_DIV];
    vsct_pkg::t_div_st n_l4 [vsct_pkg::LANES_DIV];
    vsct_pkg::t_div_st r_l4 [vsct_pkg::LANES_DIV];
    vsct_pkg::t_div_st n_l6 [vsct_pkg::LANES_DIV];
    vsct_pkg::t_div_st r_l6 [vsct_pkg::LANES_DIV];
    vsct_pkg::t_sq_st  n_q5 [vsct_pkg::LANES_SQ];
    vsct_pkg::t_sq_st  r_q5 [vsct_pkg::LANES_SQ];

    logic [63:0] n_plo, r_plo, n_phi, r_phi;

    logic signed [63:0] n_tot, r_tot;
    logic [15:0]        n_clr, r_clr;

    logic [47:0] n_stop, r_stop;
    logic        r_stop_v, r_clr_v;
    logic [15:0] r_clr_out;

    logic              w_va, w_vb, w_vq, w_vc;
    vsct_pkg::t_ctx    w_ca, w_cb, w_cq, w_cc;
    vsct_pkg::t_div_st w_la [vsct_pkg::LANES_DIV];
    vsct_pkg::t_div_st w_lb [vsct_pkg::LANES_DIV];
    vsct_pkg::t_div_st w_lc [vsct_pkg::LANES_DIV];
    vsct_pkg::t_sq_st  w_sq [vsct_pkg::LANES_SQ];

    assign w_en       = !r_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    // normalise inputs
    always_comb begin
        n_c0      = '0;
        n_c0.cls  = i_vehicle_class;
        n_c0.now  = i_now_time;
        n_c0.v    = i_cur_speed;
        n_c0.a    = (i_accel_limit == '0) ? 31'd1 : i_accel_limit;
        n_c0.bmag = i_decel_limit[31] ? 32'(-i_decel_limit) : 32'd1;
        n_c0.lim  = (i_lane_limit == '0) ? 31'd1 : i_lane_limit;
        n_c0.klim = (i_link_limit == '0) ? 31'd1 : i_link_limit;
        n_c0.len  = i_link_len;
        n_c0.d    = i_stop_distance;
        n_c0.dx1  = (i_stop_distance > vsct_pkg::DMIN) ? i_stop_distance : vsct_pkg::DMIN;
    end

    // products
    always_comb begin
        logic [31:0] dabs;
        logic [30:0] kvd;
        n_c1         = r_c0;
        dabs         = r_c0.d[31] ? 32'(-r_c0.d) : r_c0.d;
        kvd          = (r_c0.klim > r_c0.v) ? r_c0.klim - r_c0.v : r_c0.v - r_c0.klim;
        n_c1.v2      = 62'(r_c0.v) * 62'(r_c0.v);
        n_c1.l2      = 62'(r_c0.lim) * 62'(r_c0.lim);
        n_c1.k2      = 62'(r_c0.klim) * 62'(r_c0.klim);
        n_c1.kv2     = 62'(kvd) * 62'(kvd);
        n_c1.two_al  = {62'(r_c0.a) * 62'(r_c0.len), 1'b0};
        n_c1.two_ak  = {62'(r_c0.a) * 62'(r_c0.klim), 1'b0};
        n_c1.dx1b2   = {63'(r_c0.dx1) * 63'(r_c0.bmag), 1'b0};
        n_c1.mag     = {63'(r_c0.a) * 63'(dabs), 1'b0};
        n_c1.two_dxa = {63'(r_c0.dx1) * 63'(r_c0.a), 1'b0};
    end

    // first divider operands
    always_comb begin
        logic signed [63:0] sad;
        logic signed [63:0] rhs;
        n_c2        = r_c1;
        n_c2.l_ge_v = r_c1.l2 >= r_c1.v2;
        n_c2.emerg  = r_c1.dx1b2 < 64'(r_c1.v2);
        n_c2.inner  = r_c1.two_dxa + 64'(r_c1.v2);
        sad         = r_c1.d[31] ? -$signed(r_c1.mag) : $signed(r_c1.mag);
        rhs         = $signed(64'(r_c1.k2)) - $signed(64'(r_c1.v2));

        n_l2[0].rem = '0;
        n_l2[0].lo  = 64'(n_c2.l_ge_v ? r_c1.l2 - r_c1.v2 : r_c1.v2 - r_c1.l2);
        n_l2[0].den = 64'({r_c1.a, 1'b0});
        n_l2[1].rem = '0;
        n_l2[1].lo  = 64'(r_c1.l2);
        n_l2[1].den = 64'({r_c1.bmag, 1'b0});
        n_l2[2].rem = '0;
        n_l2[2].lo  = '0;
        n_l2[2].den = 64'd1;

        case (r_c1.cls)
            vsct_pkg::CLS_ENTER, vsct_pkg::CLS_READY: begin
                if (64'(r_c1.k2) < 64'(r_c1.two_al)) begin
                    n_l2[2].lo  = 64'(r_c1.two_al) + 64'(r_c1.k2);
                    n_l2[2].den = 64'(r_c1.two_ak);
                end else begin
                    n_c2.clr_sqrt = 1'b1;
                    n_l2[2].lo    = 64'({r_c1.len, 1'b0});
                    n_l2[2].den   = 64'(r_c1.a);
                end
            end
            vsct_pkg::CLS_DEPART: begin
                if (sad < rhs) begin
                    n_c2.clr_sqrt  = 1'b1;
                    n_c2.clr_sq_in = !r_c1.d[31] ? 64'(r_c1.v2) + r_c1.mag :
                                     (64'(r_c1.v2) > r_c1.mag) ? 64'(r_c1.v2) - r_c1.mag : '0;
                end else begin
                    n_l2[2].lo  = !r_c1.d[31] ? 64'(r_c1.kv2) + r_c1.mag :
                                  (64'(r_c1.kv2) > r_c1.mag) ? 64'(r_c1.kv2) - r_c1.mag : '0;
                    n_l2[2].den = 64'(r_c1.two_ak);
                end
            end
            default: begin
                n_l2[2].lo = '0;
            end
        endcase
    end

    vsct_div3 u_div_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v2),
        .i_ctx   (r_c2),
        .i_lane  (r_l2),
        .o_valid (w_va),
        .o_ctx   (w_ca),
        .o_lane  (w_la)
    );

    // braking distance and first clearance quotient
    always_comb begin
        logic [64:0] cq;
        n_c3     = w_ca;
        n_c3.dx3 = (w_ca.l_ge_v ? $signed(w_la[0].lo)
                                : -$signed(w_la[0].lo + 64'(|w_la[0].rem)))
                 + $signed(w_la[1].lo);
        cq       = 65'(w_la[2].lo) + 65'(|w_la[2].rem);
        if (!w_ca.clr_sqrt) begin
            n_c3.clr_div = vsct_pkg::sat16(cq);
        end else if (w_ca.cls != vsct_pkg::CLS_DEPART) begin
            n_c3.clr_sq_in = cq[63:0];
        end
        n_plo = 64'(w_ca.inner[31:0]) * 64'(w_ca.bmag);
        n_phi = 64'(w_ca.inner[63:32]) * 64'(w_ca.bmag);
    end

    // peak speed or cruise division operands
    always_comb begin
        logic [95:0] num96;
        logic [63:0] diff;
        logic [79:0] numc;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] den;
        n_c4        = r_c3;
        n_c4.case_a = $signed({32'b0, r_c3.dx1}) < r_c3.dx3;
        num96       = {r_phi, 32'b0} + 96'(r_plo);
        diff        = 64'($signed({32'b0, r_c3.dx1}) - r_c3.dx3);
        numc        = {diff, 16'b0};
        den         = n_c4.case_a ? 64'(33'(r_c3.bmag) + 33'(r_c3.a)) : 64'(r_c3.lim);
        hi          = n_c4.case_a ? 64'(num96[95:64]) : 64'(numc[79:64]);
        lo          = n_c4.case_a ? num96[63:0] : numc[63:0];
        n_c4.msat   = hi >= den;
        n_l4[0].rem = n_c4.msat ? '0 : hi;
        n_l4[0].lo  = n_c4.msat ? '0 : lo;
        n_l4[0].den = den;
        for (int l = 1; l < vsct_pkg::LANES_DIV; l++) begin
            n_l4[l].rem = '0;
            n_l4[l].lo  = '0;
            n_l4[l].den = 64'd1;
        end
    end

    vsct_div3 u_div_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v4),
        .i_ctx   (r_c4),
        .i_lane  (r_l4),
        .o_valid (w_vb),
        .o_ctx   (w_cb),
        .o_lane  (w_lb)
    );

    // square root operands, cruise time cap
    always_comb begin
        logic [63:0] m;
        n_c5 = w_cb;
        m    = w_cb.msat ? '1 : w_lb[0].lo;
        if (w_cb.case_a) begin
            n_c5.tcr = '0;
        end else begin
            n_c5.tcr = (m > 64'(vsct_pkg::TERM_CAP)) ? vsct_pkg::TERM_CAP : 57'(m);
        end
        n_q5[0].x    = m;
        n_q5[0].rem  = '0;
        n_q5[0].root = '0;
        n_q5[1].x    = w_cb.clr_sq_in;
        n_q5[1].rem  = '0;
        n_q5[1].root = '0;
    end

    vsct_sqrt2 u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v5),
        .i_ctx   (r_c5),
        .i_lane  (r_q5),
        .o_valid (w_vq),
        .o_ctx   (w_cq),
        .o_lane  (w_sq)
    );

    // phase times and departure clearance operands
    always_comb begin
        logic [31:0] xv;
        logic [31:0] xd;
        logic [32:0] rr;
        n_c6          = w_cq;
        xv            = w_cq.case_a ? w_sq[0].root : 32'(w_cq.lim);
        xd            = (xv >= 32'(w_cq.v)) ? xv - 32'(w_cq.v) : 32'(w_cq.v) - xv;
        rr            = 33'(w_sq[1].root) + 33'(|w_sq[1].rem);
        n_c6.clr_root = rr;
        n_c6.neg      = !w_cq.emerg && (xv < 32'(w_cq.v));

        n_l6[0].rem = '0;
        if (w_cq.emerg) begin
            n_l6[0].lo  = 64'({w_cq.dx1, 17'b0});
            n_l6[0].den = 64'(w_cq.v);
        end else begin
            n_l6[0].lo  = 64'({xd, 16'b0});
            n_l6[0].den = 64'(w_cq.a);
        end
        n_l6[1].rem = '0;
        n_l6[1].lo  = 64'({xv, 16'b0});
        n_l6[1].den = 64'(w_cq.bmag);
        n_l6[2].rem = '0;
        n_l6[2].lo  = (rr > 33'(w_cq.v)) ? 64'(rr - 33'(w_cq.v)) : '0;
        n_l6[2].den = 64'(w_cq.a);
    end

    vsct_div3 u_div_c (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v6),
        .i_ctx   (r_c6),
        .i_lane  (r_l6),
        .o_valid (w_vc),
        .o_ctx   (w_cc),
        .o_lane  (w_lc)
    );

    // total duration and final clearance
    always_comb begin
        logic signed [63:0] t0;
        logic signed [63:0] tot;
        t0  = w_cc.neg ? -$signed(w_lc[0].lo) : $signed(w_lc[0].lo);
        tot = w_cc.emerg ? $signed(w_lc[0].lo)
                         : t0 + $signed(w_lc[1].lo) + $signed(64'(w_cc.tcr));
        n_tot = (tot < vsct_pkg::TMIN) ? vsct_pkg::TMIN : tot;
        case (w_cc.cls)
            vsct_pkg::CLS_ENTER, vsct_pkg::CLS_READY: begin
                n_clr = w_cc.clr_sqrt ? vsct_pkg::sat16(65'(w_cc.clr_root)) : w_cc.clr_div;
            end
            vsct_pkg::CLS_DEPART: begin
                n_clr = w_cc.clr_sqrt
                      ? vsct_pkg::sat16(65'(w_lc[2].lo) + 65'(|w_lc[2].rem))
                      : w_cc.clr_div;
            end
            default: begin
                n_clr = '0;
            end
        endcase
    end

    // stop time: add timestamp and saturate, zero for classes other than entering
    always_comb begin
        logic [64:0] sum;
        sum    = 65'(r_c7.now) + 65'(r_tot[63:0]);
        n_stop = (sum > 65'(vsct_pkg::STOP_MAX)) ? vsct_pkg::STOP_MAX : sum[47:0];
        if (r_c7.cls != vsct_pkg::CLS_ENTER) begin
            n_stop = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0        <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_v5        <= 1'b0;
            r_v6        <= 1'b0;
            r_v7        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_v0        <= i_in_valid;
            r_v1        <= r_v0;
            r_v2        <= r_v1;
            r_v3        <= w_va;
            r_v4        <= r_v3;
            r_v5        <= w_vb;
            r_v6        <= w_vq;
            r_v7        <= w_vc;
            r_out_valid <= r_v7;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c0      <= n_c0;
            r_c1      <= n_c1;
            r_c2      <= n_c2;
            r_l2      <= n_l2;
            r_c3      <= n_c3;
            r_plo     <= n_plo;
            r_phi     <= n_phi;
            r_c4      <= n_c4;
            r_l4      <= n_l4;
            r_c5      <= n_c5;
            r_q5      <= n_q5;
            r_c6      <= n_c6;
            r_l6      <= n_l6;
            r_c7      <= w_cc;
            r_tot     <= n_tot;
            r_clr     <= n_clr;
            r_stop    <= n_stop;
            r_stop_v  <= (r_c7.cls == vsct_pkg::CLS_ENTER);
            r_clr_v   <= (r_c7.cls != vsct_pkg::CLS_LEFT);
            r_clr_out <= r_clr;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_stop_time       = r_stop;
    assign o_stop_time_valid = r_stop_v;
    assign o_clear_seconds   = r_clr_out;
    assign o_clear_valid     = r_clr_v;

    `VSCT_ASSERT(a_stop_floor, o_out_valid && o_stop_time_valid |-> o_stop_time >= 48'd655, "stop low")
    `VSCT_ASSERT(a_stop_zero, o_out_valid && !o_stop_time_valid |-> o_stop_time == '0, "stop set")
    `VSCT_ASSERT(a_clear_zero, o_out_valid && !o_clear_valid |-> o_clear_seconds == '0, "clear set")
    `VSCT_ASSERT_NEXT(a_freeze, !w_en, o_out_valid && $stable(o_stop_time) && $stable(o_clear_seconds), "beat moved in stall")

endmodule

`default_nettype wire

// ----- sim/vehicle_stop_clearance_timing_top_test.sv -----
// Testbench for vehicle_stop_clearance_timing_top: stop time and link clearance per vehicle,
// checked beat by beat against an in-bench predictor under random idling and back-pressure.
// Depends on vsct_pkg and the RTL of vehicle_stop_clearance_timing_top.
`default_nettype none

module vehicle_stop_clearance_timing_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]         cls;
        logic [47:0]        now;
        logic [30:0]        speed;
        logic signed [31:0] bar_dist;
        logic [30:0]        accel;
        logic signed [31:0] decel;
        logic [30:0]        lane;
        logic [30:0]        link;
        logic [30:0]        len;
    } t_vehicle;

    typedef struct {
        logic [47:0] stop_time;
        logic        stop_ok;
        logic [15:0] clear;
        logic        clear_ok;
    } t_timing;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [1:0]         i_vehicle_class;
    logic [47:0]        i_now_time;
    logic [30:0]        i_cur_speed;
    logic signed [31:0] i_stop_distance;
    logic [30:0]        i_accel_limit;
    logic signed [31:0] i_decel_limit;
    logic [30:0]        i_lane_limit;
    logic [30:0]        i_link_limit;
    logic [30:0]        i_link_len;
    logic               o_out_valid;
    logic               i_out_ready = 1'b1;
    logic [47:0]        o_stop_time;
    logic               o_stop_time_valid;
    logic [15:0]        o_clear_seconds;
    logic               o_clear_valid;

    t_timing pending_timings[$];
    int      mismatches;
    int      idle_cycles = 0;
    int      stall_reqs;
    int      stall_seen = 0;
    int      stall_left = 0;
    int      rx_cycle = 0;
    int      gap_next;

    vehicle_stop_clearance_timing_top dut (.*);

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic bit [63:0] mul_div(bit [63:0] x, bit [63:0] y, bit [63:0] z);
        bit [127:0] p;
        p = 128'(x) * 128'(y);
        if (p[127:64] >= z) return '1;
        return 64'(p / z);
    endfunction

    function automatic bit [63:0] root_floor(bit [63:0] x);
        bit [63:0] r;
        bit [63:0] t;
        r = 0;
        for (int i = 31; i >= 0; i--) begin
            t = r | (64'd1 << i);
            if (t * t <= x) r = t;
        end
        return r;
    endfunction

    function automatic bit [63:0] root_ceil(bit [63:0] x);
        bit [63:0] r;
        r = root_floor(x);
        return (r * r < x) ? r + 1 : r;
    endfunction

    function automatic bit [63:0] div_up(bit [63:0] n, bit [63:0] q);
        return n / q + ((n % q) != 0 ? 64'd1 : 64'd0);
    endfunction

    function automatic bit [63:0] sat_secs(bit [63:0] x);
        return (x > 64'(vsct_pkg::CLEAR_MAX)) ? 64'(vsct_pkg::CLEAR_MAX) : x;
    endfunction

    function automatic longint rate_q16(longint num, bit [63:0] q);
        bit [63:0] m;
        if (num >= 0) begin
            m = num;
            return longint'((m << 16) / q);
        end
        m = -num;
        return -longint'((m << 16) / q);
    endfunction

    function automatic longint floor_by(longint num, bit [63:0] q);
        bit [63:0] m;
        if (num >= 0) begin
            m = num;
            return longint'(m / q);
        end
        m = -num;
        return -longint'((m + q - 1) / q);
    endfunction

    function automatic t_timing stop_and_clear(t_vehicle x);
        t_timing   e;
        bit [63:0] v, a, bm, lim, kl, len, v2, dx1, l2, k2, two_al, inner, vm;
        bit [63:0] diff, tcr, mag, kv, sq, num, s, r, stop, clr;
        longint    d, dec, dx3, total, two_ad, rhs;
        bit        pos;
        v   = 64'(x.speed);
        a   = (x.accel == 0) ? 64'd1 : 64'(x.accel);
        d   = longint'(x.bar_dist);
        dec = longint'(x.decel);
        bm  = (dec < 0) ? 64'(-dec) : 64'd1;
        lim = (x.lane == 0) ? 64'd1 : 64'(x.lane);
        kl  = (x.link == 0) ? 64'd1 : 64'(x.link);
        len = 64'(x.len);
        v2  = v * v;
        stop = 0;
        clr  = 0;
        if (x.cls == vsct_pkg::CLS_ENTER) begin
            dx1 = (d > 655) ? 64'(d) : 64'd655;
            if (dx1 * 2 * bm < v2) begin
                total = longint'(((2 * dx1) << 16) / v);
            end else begin
                l2  = lim * lim;
                dx3 = floor_by(longint'(l2) - longint'(v2), 2 * a) + longint'(l2 / (2 * bm));
                if (longint'(dx1) < dx3) begin
                    inner = 2 * dx1 * a + v2;
                    vm    = root_floor(mul_div(inner, bm, bm + a));
                    total = rate_q16(longint'(vm) - longint'(v), a)
                          + longint'((vm << 16) / bm);
                end else begin
                    diff = 64'(longint'(dx1) - dx3);
                    tcr  = mul_div(diff, 64'd65536, lim);
                    if (tcr > 64'(vsct_pkg::TERM_CAP)) tcr = 64'(vsct_pkg::TERM_CAP);
                    total = rate_q16(longint'(lim) - longint'(v), a)
                          + longint'((lim << 16) / bm) + longint'(tcr);
                end
            end
            if (total < 655) total = 655;
            stop = 64'(x.now) + 64'(total);
            if (stop > 64'(vsct_pkg::STOP_MAX)) stop = 64'(vsct_pkg::STOP_MAX);
        end
        if (x.cls == vsct_pkg::CLS_ENTER || x.cls == vsct_pkg::CLS_READY) begin
            k2     = kl * kl;
            two_al = 2 * a * len;
            if (k2 < two_al) clr = sat_secs(div_up(two_al + k2, 2 * a * kl));
            else clr = sat_secs(root_ceil(div_up(2 * len, a)));
        end else if (x.cls == vsct_pkg::CLS_DEPART) begin
            two_ad = longint'(2 * a) * d;
            rhs    = longint'(kl * kl) - longint'(v2);
            mag    = (d >= 0) ? 2 * a * 64'(d) : 2 * a * 64'(-d);
            if (two_ad < rhs) begin
                if (d >= 0) s = v2 + mag;
                else s = (v2 > mag) ? v2 - mag : 64'd0;
                r   = root_ceil(s);
                clr = (r > v) ? sat_secs(div_up(r - v, a)) : 64'd0;
            end else begin
                kv  = (kl > v) ? kl - v : v - kl;
                sq  = kv * kv;
                pos = 1'b1;
                if (d >= 0) num = sq + mag;
                else if (sq > mag) num = sq - mag;
                else begin
                    num = 0;
                    pos = 1'b0;
                end
                clr = pos ? sat_secs(div_up(num, 2 * a * kl)) : 64'd0;
            end
        end
        e.stop_time = stop[47:0];
        e.stop_ok   = (x.cls == vsct_pkg::CLS_ENTER);
        e.clear     = clr[15:0];
        e.clear_ok  = (x.cls != vsct_pkg::CLS_LEFT);
        return e;
    endfunction

    task automatic send_vehicle(t_vehicle x);
        @(negedge i_clk);
        if (gap_next > 0) begin
            i_in_valid = 1'b0;
            repeat (gap_next) @(negedge i_clk);
            gap_next = 0;
        end
        i_in_valid      = 1'b1;
        i_vehicle_class = x.cls;
        i_now_time      = x.now;
        i_cur_speed     = x.speed;
        i_stop_distance = x.bar_dist;
        i_accel_limit   = x.accel;
        i_decel_limit   = x.decel;
        i_lane_limit    = x.lane;
        i_link_limit    = x.link;
        i_link_len      = x.len;
        do @(posedge i_clk); while (!o_in_ready);
        pending_timings = {pending_timings, stop_and_clear(x)};
    endtask

    task automatic go_idle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        gap_next   = 0;
    endtask

    task automatic wait_drained();
        while (pending_timings.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_vehicle plain_vehicle(logic [1:0] cls);
        t_vehicle x;
        x.cls      = cls;
        x.now      = 48'd1000 << 16;
        x.speed    = 31'd10 << 16;
        x.bar_dist = 32'sd50 << 16;
        x.accel    = 31'd2 << 16;
        x.decel    = -(32'sd3 << 16);
        x.lane     = 31'd15 << 16;
        x.link     = 31'd12 << 16;
        x.len      = 31'd30 << 16;
        return x;
    endfunction

    function automatic t_vehicle random_vehicle();
        t_vehicle x;
        x.cls = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 3) == 0) begin
            x.now      = 48'({$urandom, $urandom});
            x.speed    = 31'($urandom);
            x.bar_dist = $urandom;
            x.accel    = 31'($urandom);
            x.decel    = $urandom;
            x.lane     = 31'($urandom);
            x.link     = 31'($urandom);
            x.len      = 31'($urandom);
        end else begin
            x.now      = 48'($urandom) << $urandom_range(0, 16);
            x.speed    = 31'($urandom_range(0, 40 << 16));
            x.bar_dist = 32'($urandom_range(0, 300 << 16)) - 32'($urandom_range(0, 20 << 16));
            x.accel    = 31'($urandom_range(0, 6 << 16));
            x.decel    = -32'($urandom_range(0, 10 << 16));
            x.lane     = 31'($urandom_range(0, 35 << 16));
            x.link     = 31'($urandom_range(0, 25 << 16));
            x.len      = 31'($urandom_range(0, 200 << 16));
        end
        return x;
    endfunction

    task automatic test_directed();
        t_vehicle x;
        send_vehicle(plain_vehicle(vsct_pkg::CLS_ENTER));
        send_vehicle(plain_vehicle(vsct_pkg::CLS_READY));
        send_vehicle(plain_vehicle(vsct_pkg::CLS_DEPART));
        send_vehicle(plain_vehicle(vsct_pkg::CLS_LEFT));
        x = plain_vehicle(vsct_pkg::CLS_ENTER);
        x.speed = 31'd30 << 16; x.bar_dist = 32'sd5 << 16;
        send_vehicle(x);
        x = plain_vehicle(vsct_pkg::CLS_ENTER); x.bar_dist = 32'sd500 << 16;
        send_vehicle(x);
        x = plain_vehicle(vsct_pkg::CLS_ENTER); x.bar_dist = -(32'sd4 << 16); x.speed = '0;
        send_vehicle(x);
        x = plain_vehicle(vsct_pkg::CLS_ENTER);
        x.accel = '0; x.decel = 32'sd0; x.lane = '0; x.link = '0;
        send_vehicle(x);
        x = plain_vehicle(vsct_pkg::CLS_READY); x.accel = '0; x.link = '0; x.decel = 32'sd7;
        send_vehicle(x);
        x = plain_vehicle(vsct_pkg::CLS_DEPART); x.bar_dist = -(32'sd200 << 16);
        send_vehicle(x);
        x = plain_vehicle(vsct_pkg::CLS_DEPART);
        x.speed = 31'd30 << 16; x.bar_dist = -(32'sd1 << 16);
        send_vehicle(x);
        x = plain_vehicle(vsct_pkg::CLS_DEPART); x.bar_dist = 32'sh7FFF_FFFF; x.accel = 31'd1;
        send_vehicle(x);
        x = plain_vehicle(vsct_pkg::CLS_ENTER);
        x.now = vsct_pkg::STOP_MAX; x.bar_dist = 32'sh7FFF_FFFF; x.lane = 31'd1;
        send_vehicle(x);
        x.cls = vsct_pkg::CLS_ENTER; x.now = '0; x.speed = '1; x.bar_dist = 32'sh8000_0000;
        x.accel = '1; x.decel = 32'sh8000_0000; x.lane = '1; x.link = '1; x.len = '1;
        send_vehicle(x);
        x.cls = vsct_pkg::CLS_READY; x.accel = 31'd1; x.link = 31'd1;
        send_vehicle(x);
        x.cls = vsct_pkg::CLS_DEPART; x.speed = '0;
        send_vehicle(x);
        x.cls = vsct_pkg::CLS_LEFT; x.now = '1;
        send_vehicle(x);
        x = plain_vehicle(vsct_pkg::CLS_ENTER);
        x.speed = '0; x.len = '0; x.accel = '1; x.decel = -32'sd1;
        send_vehicle(x);
        x.cls = vsct_pkg::CLS_READY;
        send_vehicle(x);
        go_idle();
    endtask

    task automatic test_random_traffic(int n);
        int burst;
        burst = 0;
        for (int i = 0; i < n; i++) begin
            if (burst == 0) begin
                burst    = $urandom_range(1, 20);
                gap_next = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
            send_vehicle(random_vehicle());
            burst--;
        end
        go_idle();
    endtask

    task automatic test_backpressure();
        stall_reqs++;
        for (int i = 0; i < 280; i++) send_vehicle(random_vehicle());
        go_idle();
    endtask

    task automatic test_quiesce();
        test_random_traffic(30);
        wait_drained();
        test_random_traffic(30);
    endtask

    always @(negedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (stall_reqs != stall_seen) begin
            stall_seen  <= stall_reqs;
            stall_left  <= 600;
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            case ((rx_cycle / 150) % 3)
                0:       i_out_ready <= 1'b1;
                1:       i_out_ready <= ($urandom_range(0, 9) < 7);
                default: i_out_ready <= ($urandom_range(0, 9) < 3);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_timing e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_timings.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected output beat");
            end else begin
                e = pending_timings.pop_front();
                if (o_stop_time !== e.stop_time || o_stop_time_valid !== e.stop_ok
                    || o_clear_seconds !== e.clear || o_clear_valid !== e.clear_ok) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h/%b %0d/%b got %h/%b %0d/%b",
                                 e.stop_time, e.stop_ok, e.clear, e.clear_ok,
                                 o_stop_time, o_stop_time_valid, o_clear_seconds,
                                 o_clear_valid);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= 5000) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        mismatches      = 0;
        stall_reqs      = 0;
        gap_next        = 0;
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_vehicle_class = vsct_pkg::CLS_ENTER;
        i_now_time      = '0;
        i_cur_speed     = '0;
        i_stop_distance = '0;
        i_accel_limit   = '0;
        i_decel_limit   = '0;
        i_lane_limit    = '0;
        i_link_limit    = '0;
        i_link_len      = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_random_traffic(250);
        test_backpressure();
        test_quiesce();
        wait_drained();
        repeat (300) @(posedge i_clk);
        if (mismatches == 0 && pending_timings.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
